// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define IFWP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ifwp checker: property failed");

// next-cycle implication, disabled while reset is asserted
`define IFWP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ifwp checker: property failed");

`endif

// ----- design/ifwp_pkg.sv -----
// ----------------------------------------------------------------------------
// ifwp_pkg
// shared types and constants of the interrogator frame wavelength parser
// ----------------------------------------------------------------------------
package ifwp_pkg;

	// default frame geometry
	localparam int unsigned ROWS_PER_HALF_DEF = 16;
	localparam int unsigned ROW_BYTES_DEF     = 62;
	localparam int unsigned SLOTS_PER_ROW_DEF = 30;

	// field widths
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned CHANNEL_W = 5;
	localparam int unsigned SLOT_W    = 5;
	localparam int unsigned RAW_W     = 16;
	localparam int unsigned PM_W      = 21;
	localparam int unsigned BASE_W    = 21;
	localparam int unsigned THR_W     = 16;
	localparam int unsigned MARKER_W  = 8;

	// configuration port
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 21;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_WAVELENGTH_BASE = 2'd0,
		REG_VALID_THRESHOLD = 2'd1,
		REG_FIRST_MARKER    = 2'd2,
		REG_SECOND_MARKER   = 2'd3
	} cfg_reg_t;

	// register reset values
	localparam logic [BASE_W-1:0]   BASE_RST          = BASE_W'(1520000);
	localparam logic [THR_W-1:0]    THRESHOLD_RST     = THR_W'(5000);
	localparam logic [MARKER_W-1:0] FIRST_MARKER_RST  = MARKER_W'(12);
	localparam logic [MARKER_W-1:0] SECOND_MARKER_RST = MARKER_W'(14);

	// header and row lead-in lengths
	localparam int unsigned HEADER_BYTES = 2;
	localparam int unsigned ROW_SKIP     = 2;

	localparam logic [PM_W-1:0] MAX_PM = '1;

	// decoded reading, from the position tracker to the pipeline
	typedef struct packed {
		logic                 emit;
		logic [CHANNEL_W-1:0] channel;
		logic [SLOT_W-1:0]    slot;
		logic [RAW_W-1:0]     raw;
		logic                 frame_end;
		logic                 frame_good;
	} reading_t;

endpackage

// ----- design/ifwp_byte_if.sv -----
// ----------------------------------------------------------------------------
// ifwp_byte_if
// byte stream channel into the parser
// ----------------------------------------------------------------------------
interface ifwp_byte_if;
	logic                          valid;
	logic                          ready;
	logic [ifwp_pkg::BYTE_W-1:0]   data_byte;
	logic                          frame_start;

	modport source (output valid, output data_byte, output frame_start, input ready);
	modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

// ----- design/ifwp_result_if.sv -----
// ----------------------------------------------------------------------------
// ifwp_result_if
// wavelength result channel out of the parser
// ----------------------------------------------------------------------------
interface ifwp_result_if;
	logic                             valid;
	logic                             ready;
	logic [ifwp_pkg::CHANNEL_W-1:0]   channel;
	logic [ifwp_pkg::SLOT_W-1:0]      slot;
	logic [ifwp_pkg::PM_W-1:0]        wavelength_pm;
	logic                             frame_end;
	logic                             frame_good;

	modport source (output valid, output channel, output slot, output wavelength_pm,
		output frame_end, output frame_good, input ready);
	modport sink   (input valid, input channel, input slot, input wavelength_pm,
		input frame_end, input frame_good, output ready);
endinterface

// ----- design/interrogator_frame_wavelength_parser.sv -----
// ----------------------------------------------------------------------------
// interrogator_frame_wavelength_parser
// splits an interrogator frame byte stream into per-channel wavelength results
// ----------------------------------------------------------------------------
//
//  port     | dir | carries
//  ---------+-----+------------------------------------------------------
//  frame    | in  | data_byte, frame_start (one frame byte per transfer)
//  result   | out | channel, slot, wavelength_pm, frame_end, frame_good
//  cfg_*    | in  | register writes: base, threshold, two header markers
//
//  one byte per cycle while the result side keeps taking results; a high byte
//  that is taken passes through the input register and then the result
//  register before its result is offered on the result port
//  reset leaves the parser idle until a byte with frame_start arrives
//  a stalled result holds in the result register while the input register
//  keeps taking bytes until it holds one more reading; then frame.ready drops
//
module interrogator_frame_wavelength_parser #(
	parameter int unsigned ROWS_PER_HALF = ifwp_pkg::ROWS_PER_HALF_DEF,
	parameter int unsigned ROW_BYTES     = ifwp_pkg::ROW_BYTES_DEF,
	parameter int unsigned SLOTS_PER_ROW = ifwp_pkg::SLOTS_PER_ROW_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	ifwp_byte_if.sink                           frame,
	ifwp_result_if.source                       result,
	input  logic                                cfg_wr_en,
	input  logic [ifwp_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [ifwp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	// configuration registers
	logic [ifwp_pkg::BASE_W-1:0]   base_q;
	logic [ifwp_pkg::THR_W-1:0]    thr_q;
	logic [ifwp_pkg::MARKER_W-1:0] first_marker_q;
	logic [ifwp_pkg::MARKER_W-1:0] second_marker_q;

	// position decode of the byte on the input
	ifwp_pkg::reading_t reading;
	logic               take;

	// input register: only bytes that finish a reading are kept
	logic                           valid_s1;
	logic [ifwp_pkg::CHANNEL_W-1:0] channel_s1;
	logic [ifwp_pkg::SLOT_W-1:0]    slot_s1;
	logic [ifwp_pkg::RAW_W-1:0]     raw_s1;
	logic                           end_s1;
	logic                           good_s1;

	// result register
	logic                           valid_s2;
	logic [ifwp_pkg::CHANNEL_W-1:0] channel_s2;
	logic [ifwp_pkg::SLOT_W-1:0]    slot_s2;
	logic [ifwp_pkg::PM_W-1:0]      pm_s2;
	logic                           end_s2;
	logic                           good_s2;

	logic                           adv_s2;
	logic [ifwp_pkg::PM_W:0]        pm_sum;
	logic [ifwp_pkg::PM_W-1:0]      pm_calc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q          <= ifwp_pkg::BASE_RST;
			thr_q           <= ifwp_pkg::THRESHOLD_RST;
			first_marker_q  <= ifwp_pkg::FIRST_MARKER_RST;
			second_marker_q <= ifwp_pkg::SECOND_MARKER_RST;
		end else if (cfg_wr_en) begin
			unique case (ifwp_pkg::cfg_reg_t'(cfg_index))
				ifwp_pkg::REG_WAVELENGTH_BASE: base_q <= cfg_wdata[ifwp_pkg::BASE_W-1:0];
				ifwp_pkg::REG_VALID_THRESHOLD: thr_q <= cfg_wdata[ifwp_pkg::THR_W-1:0];
				ifwp_pkg::REG_FIRST_MARKER: first_marker_q <= cfg_wdata[ifwp_pkg::MARKER_W-1:0];
				ifwp_pkg::REG_SECOND_MARKER: second_marker_q <= cfg_wdata[ifwp_pkg::MARKER_W-1:0];
			endcase
		end
	end

	// result register frees up when empty or when its transfer happens
	assign adv_s2      = ~valid_s2 | result.ready;
	assign frame.ready = ~valid_s1 | adv_s2;
	assign take        = frame.valid & frame.ready;

	ifwp_position #(
		.ROWS_PER_HALF (ROWS_PER_HALF),
		.ROW_BYTES     (ROW_BYTES),
		.SLOTS_PER_ROW (SLOTS_PER_ROW)
	) u_position (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.data_byte     (frame.data_byte),
		.frame_start   (frame.frame_start),
		.first_marker  (first_marker_q),
		.second_marker (second_marker_q),
		.reading       (reading)
	);

	// threshold, base add and saturation to the field width
	always_comb begin
		pm_sum = {1'b0, base_q} + (ifwp_pkg::PM_W+1)'(raw_s1);
		if (raw_s1 > thr_q) begin
			pm_calc = pm_sum[ifwp_pkg::PM_W] ? ifwp_pkg::MAX_PM : pm_sum[ifwp_pkg::PM_W-1:0];
		end else begin
			pm_calc = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (frame.ready) begin
				valid_s1 <= take & reading.emit;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && reading.emit) begin
			channel_s1 <= reading.channel;
			slot_s1    <= reading.slot;
			raw_s1     <= reading.raw;
			end_s1     <= reading.frame_end;
			good_s1    <= reading.frame_good;
		end
		if (adv_s2 && valid_s1) begin
			channel_s2 <= channel_s1;
			slot_s2    <= slot_s1;
			pm_s2      <= pm_calc;
			end_s2     <= end_s1;
			good_s2    <= good_s1;
		end
	end

	assign result.valid         = valid_s2;
	assign result.channel       = channel_s2;
	assign result.slot          = slot_s2;
	assign result.wavelength_pm = pm_s2;
	assign result.frame_end     = end_s2;
	assign result.frame_good    = good_s2;

endmodule

// ----- design/ifwp_position.sv -----
// ----------------------------------------------------------------------------
// ifwp_position
// frame position tracker: header, row and column counters, marker check
// ----------------------------------------------------------------------------
module ifwp_position #(
	parameter int unsigned ROWS_PER_HALF = ifwp_pkg::ROWS_PER_HALF_DEF,
	parameter int unsigned ROW_BYTES     = ifwp_pkg::ROW_BYTES_DEF,
	parameter int unsigned SLOTS_PER_ROW = ifwp_pkg::SLOTS_PER_ROW_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            take,
	input  logic [ifwp_pkg::BYTE_W-1:0]     data_byte,
	input  logic                            frame_start,
	input  logic [ifwp_pkg::MARKER_W-1:0]   first_marker,
	input  logic [ifwp_pkg::MARKER_W-1:0]   second_marker,
	output ifwp_pkg::reading_t              reading
);

	localparam int unsigned ROW_W = (ROWS_PER_HALF > 1) ? $clog2(ROWS_PER_HALF) : 1;
	localparam int unsigned COL_W = $clog2(ROW_BYTES);
	localparam int unsigned FIT_SLOTS = (ROW_BYTES - ifwp_pkg::ROW_SKIP) / 2;
	localparam int unsigned USED_SLOTS = (SLOTS_PER_ROW < FIT_SLOTS) ? SLOTS_PER_ROW : FIT_SLOTS;
	localparam int unsigned COL_LIMIT = ifwp_pkg::ROW_SKIP + 2 * USED_SLOTS;
	localparam int unsigned COL_FINAL = COL_LIMIT - 1;
	localparam int unsigned CH_X = $clog2(2 * ROWS_PER_HALF + 1) + ifwp_pkg::CHANNEL_W;
	localparam int unsigned SL_X = COL_W + ifwp_pkg::SLOT_W;

	logic             active_q, half_q, hdr_q, hidx_q, mok_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [ifwp_pkg::BYTE_W-1:0] low_q;

	logic             eff_active, eff_half, eff_hdr, eff_hidx, eff_mok;
	logic [ROW_W-1:0] eff_row;
	logic [COL_W-1:0] eff_col;
	logic             nxt_active, nxt_half, nxt_hdr, nxt_hidx;
	logic [ROW_W-1:0] nxt_row;
	logic [COL_W-1:0] nxt_col;
	logic             marker_fail, in_slots;
	logic [CH_X-1:0]  ch_wide;
	logic [SL_X-1:0]  sl_wide;

	always_comb begin
		// a start mark forces position zero whatever the counters hold
		eff_active = frame_start | active_q;
		eff_half   = frame_start ? 1'b0 : half_q;
		eff_hdr    = frame_start | hdr_q;
		eff_hidx   = frame_start ? 1'b0 : hidx_q;
		eff_row    = frame_start ? '0 : row_q;
		eff_col    = frame_start ? '0 : col_q;
		eff_mok    = frame_start | mok_q;

		nxt_active  = eff_active;
		nxt_half    = eff_half;
		nxt_hdr     = eff_hdr;
		nxt_hidx    = eff_hidx;
		nxt_row     = eff_row;
		nxt_col     = eff_col;
		marker_fail = 1'b0;
		in_slots    = 1'b0;

		if (eff_active) begin
			if (eff_hdr) begin
				if (eff_hidx) begin
					marker_fail = data_byte != (eff_half ? second_marker : first_marker);
					nxt_hdr = 1'b0;
					nxt_row = '0;
					nxt_col = '0;
				end else begin
					nxt_hidx = 1'b1;
				end
			end else begin
				in_slots = (eff_col >= COL_W'(ifwp_pkg::ROW_SKIP)) &&
					({1'b0, eff_col} < (COL_W+1)'(COL_LIMIT));
				if (eff_col == COL_W'(ROW_BYTES - 1)) begin
					nxt_col = '0;
					if (eff_row == ROW_W'(ROWS_PER_HALF - 1)) begin
						if (eff_half) begin
							nxt_active = 1'b0;
						end else begin
							nxt_half = 1'b1;
							nxt_hdr  = 1'b1;
							nxt_hidx = 1'b0;
						end
					end else begin
						nxt_row = eff_row + ROW_W'(1);
					end
				end else begin
					nxt_col = eff_col + COL_W'(1);
				end
			end
		end
	end

	always_comb begin
		ch_wide = CH_X'(eff_row) + (eff_half ? CH_X'(ROWS_PER_HALF) : '0);
		sl_wide = (SL_X'(eff_col) - SL_X'(ifwp_pkg::ROW_SKIP)) >> 1;
		reading.emit      = in_slots & eff_col[0];
		reading.channel   = ch_wide[ifwp_pkg::CHANNEL_W-1:0];
		reading.slot      = sl_wide[ifwp_pkg::SLOT_W-1:0];
		reading.raw       = {data_byte, low_q};
		reading.frame_end = eff_half && (eff_row == ROW_W'(ROWS_PER_HALF - 1)) &&
			(eff_col == COL_W'(COL_FINAL));
		reading.frame_good = reading.frame_end & eff_mok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			half_q   <= 1'b0;
			hdr_q    <= 1'b0;
			hidx_q   <= 1'b0;
			mok_q    <= 1'b1;
			row_q    <= '0;
			col_q    <= '0;
			low_q    <= '0;
		end else if (take) begin
			active_q <= nxt_active;
			half_q   <= nxt_half;
			hdr_q    <= nxt_hdr;
			hidx_q   <= nxt_hidx;
			mok_q    <= eff_mok & ~marker_fail;
			row_q    <= nxt_row;
			col_q    <= nxt_col;
			if (in_slots && !eff_col[0]) begin
				low_q <= data_byte;
			end
		end
	end

endmodule

// ----- design/ifwp_checker.sv -----
// ----------------------------------------------------------------------------
// ifwp_checker
// port-level checks of the parser, attached by bind
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ifwp_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [ifwp_pkg::CHANNEL_W-1:0]   channel,
	input logic [ifwp_pkg::SLOT_W-1:0]      slot,
	input logic [ifwp_pkg::PM_W-1:0]        wavelength_pm,
	input logic                             frame_end,
	input logic                             frame_good
);

	localparam int unsigned FIELDS_W = ifwp_pkg::CHANNEL_W + ifwp_pkg::SLOT_W +
		ifwp_pkg::PM_W + 2;

	logic                in_xfer;
	logic                end_xfer;
	logic [FIELDS_W-1:0] out_fields;

	assign in_xfer    = in_valid & in_ready;
	assign end_xfer   = out_valid & out_ready & frame_end;
	assign out_fields = {channel, slot, wavelength_pm, frame_end, frame_good};

	// stalled result holds
	`IFWP_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_fields))

	// good flag only rides on the frame's last reading
	`IFWP_ASSERT_IMP(a_good_on_end, clk, arst_n, out_valid && !frame_end, !frame_good)

	// an empty output fills after a byte transfer, through the input and result registers
	`IFWP_ASSERT_IMP(a_fill_latency, clk, arst_n, $rose(out_valid), $past(in_xfer, 2))

	// a frame end transfer is never followed at once by another
	`IFWP_ASSERT_NXT(a_end_spacing, clk, arst_n, end_xfer, !end_xfer)

endmodule

bind interrogator_frame_wavelength_parser ifwp_checker u_ifwp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (frame.valid),
	.in_ready      (frame.ready),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.channel       (result.channel),
	.slot          (result.slot),
	.wavelength_pm (result.wavelength_pm),
	.frame_end     (result.frame_end),
	.frame_good    (result.frame_good)
);

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the interrogator frame wavelength parser: bytes go
// in through a queue-fed driver with random gaps, readings are predicted per
// accepted byte and compared field by field, under random result stalls, in the monitor
// ----------------------------------------------------------------------------
module tb;

	// frame geometry at the default parameters of the parser
	localparam int unsigned HALF_LEN   = ifwp_pkg::HEADER_BYTES +
		ifwp_pkg::ROWS_PER_HALF_DEF * ifwp_pkg::ROW_BYTES_DEF;
	localparam int unsigned FRAME_LEN  = 2 * HALF_LEN;
	localparam int unsigned SLOT_FIT   = (ifwp_pkg::ROW_BYTES_DEF - ifwp_pkg::ROW_SKIP) / 2;
	localparam int unsigned SLOTS_USED = (ifwp_pkg::SLOTS_PER_ROW_DEF < SLOT_FIT) ?
		ifwp_pkg::SLOTS_PER_ROW_DEF : SLOT_FIT;
	localparam int unsigned BASE_MAX   = 2000000;
	// bytes of the long frame in each phase
	localparam int unsigned PHASE_LEN  = 170;

	// slowest legal run is far below this, with every byte and every reading
	// waiting out the longest gap
	localparam int unsigned CYCLE_LIMIT = 1000000;
	// pipeline slack after the last transfer before the block counts as idle
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned PRINT_CAP = 40;

	typedef struct packed {
		logic [ifwp_pkg::BYTE_W-1:0] data;
		logic                        start;
	} frame_byte_t;

	typedef struct packed {
		logic [ifwp_pkg::CHANNEL_W-1:0] channel;
		logic [ifwp_pkg::SLOT_W-1:0]    slot;
		logic [ifwp_pkg::PM_W-1:0]      pm;
		logic                           frame_end;
		logic                           frame_good;
	} wavelength_reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en;
	logic [ifwp_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [ifwp_pkg::CFG_DATA_W-1:0]  cfg_wdata;

	ifwp_byte_if   frame_ch ();
	ifwp_result_if res_ch ();

	interrogator_frame_wavelength_parser uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame     (frame_ch),
		.result    (res_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// bytes waiting for the driver, readings waiting for the parser
	frame_byte_t         pending_bytes[$];
	wavelength_reading_t expected_readings[$];

	// shadow of the register file
	logic [ifwp_pkg::BASE_W-1:0]   cfg_base      = ifwp_pkg::BASE_RST;
	logic [ifwp_pkg::THR_W-1:0]    cfg_threshold = ifwp_pkg::THRESHOLD_RST;
	logic [ifwp_pkg::MARKER_W-1:0] head_marker   = ifwp_pkg::FIRST_MARKER_RST;
	logic [ifwp_pkg::MARKER_W-1:0] mid_marker    = ifwp_pkg::SECOND_MARKER_RST;

	// shadow of the frame tracker; idle until a start mark
	int unsigned                 frame_pos     = FRAME_LEN;
	logic [ifwp_pkg::BYTE_W-1:0] low_byte      = '0;
	logic                        markers_match = 1'b1;

	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	bit          byte_taken = 1'b0;
	bit          smooth = 1'b0;
	int unsigned mode_left = 0;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic report(input string msg);
		error_count++;
		if (error_count <= PRINT_CAP) begin
			$display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
		end
	endtask

	// mostly short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// one accepted byte through the frame tracker; queues a reading on a high byte
	task automatic parse_byte(input logic [ifwp_pkg::BYTE_W-1:0] b, input logic start);
		int unsigned pos, p, q, row, col, off;
		logic half;
		logic [ifwp_pkg::RAW_W-1:0] raw;
		logic [ifwp_pkg::PM_W:0] sum;
		wavelength_reading_t r;
		if (start) begin
			frame_pos = 0;
			markers_match = 1'b1;
		end
		// past the frame or never started: ignored
		if (frame_pos >= FRAME_LEN) return;
		pos = frame_pos;
		frame_pos = pos + 1;
		if (pos == 1 && b != head_marker) markers_match = 1'b0;
		if (pos == HALF_LEN + 1 && b != mid_marker) markers_match = 1'b0;
		half = (pos >= HALF_LEN);
		p = half ? pos - HALF_LEN : pos;
		if (p < ifwp_pkg::HEADER_BYTES) return;
		q = p - ifwp_pkg::HEADER_BYTES;
		row = q / ifwp_pkg::ROW_BYTES_DEF;
		col = q % ifwp_pkg::ROW_BYTES_DEF;
		if (col < ifwp_pkg::ROW_SKIP) return;
		off = col - ifwp_pkg::ROW_SKIP;
		// bytes beyond the readings that fit in a row are skipped
		if (off >= 2 * SLOTS_USED) return;
		if (off % 2 == 0) begin
			low_byte = b;
			return;
		end
		raw = {b, low_byte};
		if (raw > cfg_threshold) begin
			sum = {1'b0, cfg_base} + (ifwp_pkg::PM_W+1)'(raw);
			r.pm = (sum > ifwp_pkg::MAX_PM) ? ifwp_pkg::MAX_PM : sum[ifwp_pkg::PM_W-1:0];
		end else begin
			r.pm = '0;
		end
		r.channel = ifwp_pkg::CHANNEL_W'(row + (half ? ifwp_pkg::ROWS_PER_HALF_DEF : 0));
		r.slot = ifwp_pkg::SLOT_W'(off / 2);
		r.frame_end = half && row == ifwp_pkg::ROWS_PER_HALF_DEF - 1 &&
			off / 2 == SLOTS_USED - 1;
		r.frame_good = r.frame_end ? markers_match : 1'b0;
		expected_readings.push_back(r);
	endtask

	// ------------------------------------------------------------------
	// traffic shaping: alternate stretches of random idling and none
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (mode_left == 0) begin
			smooth <= ~smooth;
			mode_left <= $urandom_range(40, 400);
		end else begin
			mode_left <= mode_left - 1;
		end
	end

	// ------------------------------------------------------------------
	// byte driver: changes the channel at the falling edge only
	// ------------------------------------------------------------------
	always @(negedge clk) begin : byte_driver
		frame_byte_t nxt;
		if (!arst_n) begin
			frame_ch.valid <= 1'b0;
		end else if (!frame_ch.valid || byte_taken) begin
			byte_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				frame_ch.valid <= 1'b0;
			end else if (pending_bytes.size() > 0) begin
				nxt = pending_bytes.pop_front();
				frame_ch.valid <= 1'b1;
				frame_ch.data_byte <= nxt.data;
				frame_ch.frame_start <= nxt.start;
				gap_left = smooth ? 0 : pick_gap();
			end else begin
				frame_ch.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// result sink: random back-pressure
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else if (smooth) begin
			res_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
			stall_left = pick_gap();
		end
	end

	// ------------------------------------------------------------------
	// monitor: both channels sampled at the rising edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		wavelength_reading_t want;
		if (arst_n) begin
			// predict first so a reading is queued before it could show up
			if (frame_ch.valid && frame_ch.ready) begin
				parse_byte(frame_ch.data_byte, frame_ch.frame_start);
				byte_taken = 1'b1;
			end
			if (res_ch.valid && res_ch.ready) begin
				if (expected_readings.size() == 0) begin
					report($sformatf("reading ch %0d slot %0d with none expected",
						res_ch.channel, res_ch.slot));
				end else begin
					want = expected_readings.pop_front();
					if (res_ch.channel !== want.channel)
						report($sformatf("channel got %0d want %0d", res_ch.channel,
							want.channel));
					if (res_ch.slot !== want.slot)
						report($sformatf("slot got %0d want %0d", res_ch.slot, want.slot));
					if (res_ch.wavelength_pm !== want.pm)
						report($sformatf("ch %0d slot %0d wavelength got %0d want %0d",
							want.channel, want.slot, res_ch.wavelength_pm, want.pm));
					if (res_ch.frame_end !== want.frame_end)
						report($sformatf("ch %0d slot %0d frame_end got %0d want %0d",
							want.channel, want.slot, res_ch.frame_end, want.frame_end));
					if (res_ch.frame_good !== want.frame_good)
						report($sformatf("ch %0d slot %0d frame_good got %0d want %0d",
							want.channel, want.slot, res_ch.frame_good, want.frame_good));
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: timeout after %0d cycles", cycle_count);
			$display("tb: done, errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	task automatic push_byte(input logic [ifwp_pkg::BYTE_W-1:0] b, input logic start);
		frame_byte_t fb;
		fb.data = b;
		fb.start = start;
		pending_bytes.push_back(fb);
	endtask

	// little-endian reading, low byte first
	task automatic push_reading(input logic [ifwp_pkg::RAW_W-1:0] raw);
		push_byte(raw[7:0], 1'b0);
		push_byte(raw[15:8], 1'b0);
	endtask

	// every byte accepted, every reading back, pipeline settled
	task automatic wait_drained();
		while (pending_bytes.size() != 0 || frame_ch.valid || expected_readings.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input ifwp_pkg::cfg_reg_t idx,
			input logic [ifwp_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			ifwp_pkg::REG_WAVELENGTH_BASE: cfg_base = val[ifwp_pkg::BASE_W-1:0];
			ifwp_pkg::REG_VALID_THRESHOLD: cfg_threshold = val[ifwp_pkg::THR_W-1:0];
			ifwp_pkg::REG_FIRST_MARKER:    head_marker = val[ifwp_pkg::MARKER_W-1:0];
			ifwp_pkg::REG_SECOND_MARKER:   mid_marker = val[ifwp_pkg::MARKER_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_config(input logic [ifwp_pkg::BASE_W-1:0] base,
			input logic [ifwp_pkg::THR_W-1:0] thr,
			input logic [ifwp_pkg::MARKER_W-1:0] m1, input logic [ifwp_pkg::MARKER_W-1:0] m2);
		write_reg(ifwp_pkg::REG_WAVELENGTH_BASE, ifwp_pkg::CFG_DATA_W'(base));
		write_reg(ifwp_pkg::REG_VALID_THRESHOLD, ifwp_pkg::CFG_DATA_W'(thr));
		write_reg(ifwp_pkg::REG_FIRST_MARKER, ifwp_pkg::CFG_DATA_W'(m1));
		write_reg(ifwp_pkg::REG_SECOND_MARKER, ifwp_pkg::CFG_DATA_W'(m2));
	endtask

	// raw values around the threshold and at the ends of the range
	function automatic logic [ifwp_pkg::RAW_W-1:0] pick_corner_raw();
		case ($urandom_range(0, 4))
			0: return cfg_threshold - 1'b1;
			1: return cfg_threshold;
			2: return cfg_threshold + 1'b1;
			3: return '0;
			default: return '1;
		endcase
	endfunction

	// well-formed frame with random content, possibly cut after len bytes;
	// split > 0 holds the byte stream at that point until all readings are back
	task automatic push_frame(input int unsigned len, input bit m1_ok, input bit m2_ok,
			input int unsigned split);
		logic [ifwp_pkg::BYTE_W-1:0] img [0:FRAME_LEN-1];
		logic [ifwp_pkg::RAW_W-1:0] raw;
		int unsigned idx;
		for (int i = 0; i < FRAME_LEN; i++) img[i] = ifwp_pkg::BYTE_W'($urandom_range(0, 255));
		img[1] = m1_ok ? head_marker : head_marker ^ (8'd1 << $urandom_range(0, 7));
		img[HALF_LEN + 1] = m2_ok ? mid_marker : mid_marker ^ (8'd1 << $urandom_range(0, 7));
		for (int h = 0; h < 2; h++)
			for (int r = 0; r < ifwp_pkg::ROWS_PER_HALF_DEF; r++)
				for (int s = 0; s < SLOTS_USED; s++)
					if ($urandom_range(0, 3) == 0) begin
						raw = pick_corner_raw();
						idx = h * HALF_LEN + ifwp_pkg::HEADER_BYTES +
							r * ifwp_pkg::ROW_BYTES_DEF + ifwp_pkg::ROW_SKIP + 2 * s;
						img[idx] = raw[7:0];
						img[idx + 1] = raw[15:8];
					end
		for (int i = 0; i < len && i < FRAME_LEN; i++) begin
			push_byte(img[i], i == 0);
			if (split != 0 && i + 1 == split) wait_drained();
		end
	endtask

	// junk with the odd start mark
	task automatic push_noise(input int unsigned n);
		for (int i = 0; i < n; i++)
			push_byte(ifwp_pkg::BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
	endtask

	// noise, a cut-short frame or two, then a longer frame cut after PHASE_LEN bytes
	task automatic run_phase(input bit m1_ok, input bit m2_ok, input int unsigned split);
		push_noise($urandom_range(5, 20));
		repeat ($urandom_range(1, 2))
			push_frame($urandom_range(2, 40), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 0);
		push_frame(PHASE_LEN, m1_ok, m2_ok, split);
		wait_drained();
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		cfg_wr_en = 1'b0;
		cfg_index = ifwp_pkg::REG_WAVELENGTH_BASE;
		cfg_wdata = '0;
		frame_ch.valid = 1'b0;
		frame_ch.data_byte = '0;
		frame_ch.frame_start = 1'b0;
		res_ch.ready = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// directed, at reset settings
		push_byte(8'h00, 1'b0);                   // idle before any start: ignored
		push_byte(8'hFF, 1'b0);
		push_byte(8'hA5, 1'b1);                   // start mark
		push_byte(ifwp_pkg::FIRST_MARKER_RST, 1'b0);
		push_byte(8'h00, 1'b0);                   // row lead-in
		push_byte(8'hFF, 1'b0);
		push_reading(16'h0000);
		push_reading(16'hFFFF);
		push_reading(ifwp_pkg::THRESHOLD_RST);             // exactly at threshold: zero
		push_reading(ifwp_pkg::THRESHOLD_RST + 1'b1);      // just above
		push_byte(8'h55, 1'b1);                   // restart mid-row
		push_byte(8'h00, 1'b0);                   // wrong first marker
		push_byte(8'h5A, 1'b0);
		push_byte(8'h3C, 1'b0);
		push_reading(16'h8000);
		push_byte(8'h01, 1'b1);                   // restart again, left dangling
		wait_drained();

		// reset settings
		run_phase(1'b1, 1'b1, 0);

		// low extremes, everything at or below threshold, bad first marker
		set_config('0, '1, '0, 8'hFF);
		run_phase(1'b0, 1'b1, 0);

		// base near the top of the field with zero threshold saturates large sums
		set_config(ifwp_pkg::MAX_PM - ifwp_pkg::BASE_W'(30000), '0, 8'hFF, '0);
		run_phase(1'b1, 1'b0, 0);

		// random settings and a sender hold-off mid-frame
		set_config(ifwp_pkg::BASE_W'($urandom_range(0, BASE_MAX)),
			ifwp_pkg::THR_W'($urandom_range(0, 65535)),
			ifwp_pkg::MARKER_W'($urandom_range(0, 255)),
			ifwp_pkg::MARKER_W'($urandom_range(0, 255)));
		run_phase(1'b1, 1'b1, $urandom_range(40, 160));

		if (error_count == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule
